// File: src/fsu_pkg.sv
// Shared types, constants and arithmetic helpers of the saturating FIR filter.
// No dependencies; every other file of the block refers to this package.
package fsu_pkg;

	// Storage size of the delay ring and of the coefficient store.
	localparam int MAX_TAPS = 16;
	localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CNT_W = $clog2(MAX_TAPS + 1);

	// Fixed field widths.
	localparam int SMP_W = 16;
	localparam int COEF_W = 16;
	localparam int CIDX_W = 4;
	localparam int TAPCFG_W = 5;
	localparam int PROD_W = SMP_W + COEF_W;
	localparam int ACC_W = PROD_W + $clog2(MAX_TAPS);
	localparam int RND_SHIFT = 12;

	// Stream and configuration port widths.
	localparam int IN_DATA_W = 40;
	localparam int OUT_DATA_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = TAPCFG_W;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAPS = 1'd1;

	// Depth of the queue between front and back.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Function code carried in the input tuser.
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_COEF = 1'b1;

	typedef enum logic [1:0] {
		KIND_SAMPLE,
		KIND_COEF,
		KIND_DROP
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic signed [SMP_W-1:0] sample;
		logic [CIDX_W-1:0] coef_index;
		logic signed [COEF_W-1:0] coef_value;
	} item_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MAC,
		BK_DRAIN,
		BK_DONE
	} back_state_t;

	// Round a Q9.27 sum to Q1.15 (ties toward plus infinity) and saturate.
	function automatic logic signed [SMP_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W:0] biased;
		logic signed [ACC_W:0] shifted;
		logic signed [ACC_W:0] pos_lim;
		logic signed [ACC_W:0] neg_lim;
		biased = $signed({acc[ACC_W-1], acc}) + $signed((ACC_W + 1)'(2048));
		shifted = biased >>> RND_SHIFT;
		pos_lim = (ACC_W + 1)'(32767);
		neg_lim = -$signed((ACC_W + 1)'(32768));
		if (shifted > pos_lim) begin
			round_sat = 16'sh7fff;
		end else if (shifted < neg_lim) begin
			round_sat = 16'sh8000;
		end else begin
			round_sat = shifted[SMP_W-1:0];
		end
	endfunction

endpackage

// File: src/fsu_front.sv
// Front end: unpacks input transfers, classifies them and queues them for the back end.
// Depends on fsu_pkg.
module fsu_front (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [fsu_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic s_tuser,
	output logic q_valid,
	input  logic q_pop,
	output fsu_pkg::item_t q_item
);

	fsu_pkg::item_t in_item;
	fsu_pkg::item_t queue_q [fsu_pkg::QDEPTH];
	logic [fsu_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [fsu_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [fsu_pkg::QCNT_W-1:0] count_q;
	logic push;
	logic pop;

	// Unpack the fields and classify the item; out-of-store coefficient loads are dropped.
	always_comb begin
		in_item.sample = s_tdata[15:0];
		in_item.coef_index = s_tdata[19:16];
		in_item.coef_value = s_tdata[35:20];
		if (s_tuser == fsu_pkg::FUNC_COEF) begin
			if (32'(s_tdata[19:16]) < fsu_pkg::MAX_TAPS) begin
				in_item.kind = fsu_pkg::KIND_COEF;
			end else begin
				in_item.kind = fsu_pkg::KIND_DROP;
			end
		end else begin
			in_item.kind = fsu_pkg::KIND_SAMPLE;
		end
	end

	assign s_tready = (count_q != fsu_pkg::QCNT_W'(fsu_pkg::QDEPTH));
	assign push = s_tvalid && s_tready && (in_item.kind != fsu_pkg::KIND_DROP);
	assign pop = q_pop && q_valid;
	assign q_valid = (count_q != '0);
	assign q_item = queue_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_item;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == fsu_pkg::QDEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == fsu_pkg::QDEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: src/fsu_back.sv
// Back end: coefficient store, delay ring, multiply-accumulate sequencer and output register.
// Depends on fsu_pkg.
module fsu_back (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [fsu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fsu_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic q_valid,
	output logic q_pop,
	input  fsu_pkg::item_t q_item,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [fsu_pkg::OUT_DATA_W-1:0] m_tdata
);

	fsu_pkg::back_state_t state_q;
	fsu_pkg::back_state_t state_d;

	logic enable_q;
	logic [fsu_pkg::TAPCFG_W-1:0] taps_q;
	logic signed [fsu_pkg::SMP_W-1:0] delay_q [fsu_pkg::MAX_TAPS];
	logic signed [fsu_pkg::COEF_W-1:0] coef_q [fsu_pkg::MAX_TAPS];
	logic [fsu_pkg::IDX_W-1:0] wp_q;
	logic [fsu_pkg::IDX_W-1:0] idx_q;
	logic [fsu_pkg::CNT_W-1:0] w_q;
	logic byp_q;
	logic signed [fsu_pkg::SMP_W-1:0] res_q;
	logic signed [fsu_pkg::PROD_W-1:0] prod_s1;
	logic prod_vld_s1;
	logic signed [fsu_pkg::ACC_W-1:0] acc_q;
	logic out_vld_q;
	logic signed [fsu_pkg::SMP_W-1:0] out_data_q;

	logic [fsu_pkg::CNT_W-1:0] n_eff;
	logic [fsu_pkg::CNT_W-1:0] n_last;
	logic [fsu_pkg::IDX_W-1:0] wp_eff;
	logic [fsu_pkg::IDX_W-1:0] wp_next;
	logic out_free;
	logic start_sample;
	logic load_coef;

	// Effective tap count and the write position of the next sample.
	always_comb begin
		if (taps_q == '0) begin
			n_eff = fsu_pkg::CNT_W'(1);
		end else if (32'(taps_q) > fsu_pkg::MAX_TAPS) begin
			n_eff = fsu_pkg::CNT_W'(fsu_pkg::MAX_TAPS);
		end else begin
			n_eff = fsu_pkg::CNT_W'(taps_q);
		end
		n_last = n_eff - 1'b1;
		wp_eff = (fsu_pkg::CNT_W'(wp_q) >= n_eff) ? '0 : wp_q;
		wp_next = (fsu_pkg::CNT_W'(wp_eff) + 1'b1 >= n_eff) ? '0 : wp_eff + 1'b1;
	end

	assign out_free = !out_vld_q || m_tready;
	assign q_pop = (state_q == fsu_pkg::BK_IDLE);
	assign start_sample = q_pop && q_valid && (q_item.kind == fsu_pkg::KIND_SAMPLE);
	assign load_coef = q_pop && q_valid && (q_item.kind == fsu_pkg::KIND_COEF);

	// Sequencer: next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			fsu_pkg::BK_IDLE: begin
				if (start_sample) begin
					state_d = enable_q ? fsu_pkg::BK_MAC : fsu_pkg::BK_DONE;
				end
			end
			fsu_pkg::BK_MAC: begin
				if (w_q == n_last) begin
					state_d = fsu_pkg::BK_DRAIN;
				end
			end
			fsu_pkg::BK_DRAIN: begin
				state_d = fsu_pkg::BK_DONE;
			end
			fsu_pkg::BK_DONE: begin
				if (out_free) begin
					state_d = fsu_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = fsu_pkg::BK_IDLE;
			end
		endcase
	end

	// State, configuration, stores and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsu_pkg::BK_IDLE;
			enable_q <= 1'b1;
			taps_q <= fsu_pkg::TAPCFG_W'(16);
			wp_q <= '0;
			prod_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
			for (int i = 0; i < fsu_pkg::MAX_TAPS; i++) begin
				delay_q[i] <= '0;
				coef_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			prod_vld_s1 <= (state_q == fsu_pkg::BK_MAC);
			if (cfg_we) begin
				case (cfg_index)
					fsu_pkg::REG_ENABLE: enable_q <= cfg_data[0];
					fsu_pkg::REG_TAPS: taps_q <= cfg_data[fsu_pkg::TAPCFG_W-1:0];
					default: ;
				endcase
			end
			if (load_coef) begin
				coef_q[fsu_pkg::IDX_W'(q_item.coef_index)] <= q_item.coef_value;
			end
			if (start_sample) begin
				delay_q[wp_eff] <= q_item.sample;
				wp_q <= wp_next;
			end
			if (state_q == fsu_pkg::BK_DONE && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Multiply-accumulate datapath, one tap per cycle through a single multiplier.
	always_ff @(posedge clk) begin
		if (start_sample) begin
			idx_q <= wp_eff;
			w_q <= '0;
			acc_q <= '0;
			byp_q <= !enable_q;
			res_q <= q_item.sample;
		end else if (prod_vld_s1) begin
			acc_q <= acc_q + fsu_pkg::ACC_W'(prod_s1);
		end
		if (state_q == fsu_pkg::BK_MAC) begin
			prod_s1 <= delay_q[idx_q] * coef_q[w_q[fsu_pkg::IDX_W-1:0]];
			idx_q <= (idx_q == '0) ? n_last[fsu_pkg::IDX_W-1:0] : idx_q - 1'b1;
			w_q <= w_q + 1'b1;
		end
		if (state_q == fsu_pkg::BK_DONE && out_free) begin
			out_data_q <= byp_q ? res_q : fsu_pkg::round_sat(acc_q);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = out_data_q;

endmodule

// File: src/fir_filter_saturating_unit.sv
// Saturating FIR filter, top level: front end with item queue, back end with one MAC unit.
// A filtered sample passes the queue, the MAC steps over the taps, the product register, the drain
// and done states and the output register; a passed-through sample skips MAC and drain. A coefficient
// load is written when popped in the idle state. The single multiplier that steps through the taps sets
// the filter rate; the front keeps accepting transfers while the queue has room.
// Reset (arst_n, asynchronous): clears the delay ring, coefficients, write pointer and queue.
module fir_filter_saturating_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [fsu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fsu_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	// sample [15:0], coef_index [19:16], coef_value [35:20], zero fill [39:36]
	input  logic [fsu_pkg::IN_DATA_W-1:0] s_tdata,
	// func [0]
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// result [15:0]
	output logic [fsu_pkg::OUT_DATA_W-1:0] m_tdata
);

	logic q_valid;
	logic q_pop;
	fsu_pkg::item_t q_item;

	// Front end: accepts and queues items.
	fsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item)
	);

	// Back end: executes loads and filter steps.
	fsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// File: src/fsu_checker.sv
// Port-level checker for the saturating FIR filter, bound to the top level.
// Depends on fsu_pkg and fir_filter_saturating_unit.
module fsu_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic s_tuser,
	input logic m_tvalid,
	input logic m_tready,
	input logic [fsu_pkg::OUT_DATA_W-1:0] m_tdata
);

	logic [2:0] pending_q;
	logic in_smp;
	logic out_xfer;

	assign in_smp = s_tvalid && s_tready && (s_tuser == fsu_pkg::FUNC_SAMPLE);
	assign out_xfer = m_tvalid && m_tready;

	// Count sample transfers whose result has not yet been delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_smp && !out_xfer) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_xfer && !in_smp) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// No result is shown without an outstanding sample.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pending_q != 3'd0)
		else $error("result without a pending sample");

	// Queue, back end and output register bound the samples in flight.
	a_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'(fsu_pkg::QDEPTH + 2))
		else $error("too many samples in flight");

endmodule

bind fir_filter_saturating_unit fsu_checker u_fsu_checker (.*);
